### design/sbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared types, widths and codes for the sparse bit set table unit.
// ----------------------------------------------------------------------------
package sbt_pkg;

    // Default sizing
    localparam int ENTRIES_DEF  = 16;
    localparam int BN_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int BN_W     = 16;
    localparam int WORD_W   = BN_W - 5;
    localparam int MASK_W   = 32;
    localparam int SEL_W    = 5;
    localparam int OP_W     = 2;
    localparam int BITS_W   = 10;
    localparam int WORDS_W  = 5;
    localparam int STAT_W   = 2;
    localparam int IN_TW    = 24;
    localparam int OUT_TW   = 24;

    // Request codes
    localparam logic [OP_W-1:0] OP_TEST  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    // One table entry as held in the RAM
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [MASK_W-1:0] mask;
    } entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } stat_t;

endpackage

### design/sparse_bitset_table_unit.sv
`timescale 1ns / 1ps
// Each request is handled by a scan of the table RAM, one entry a cycle, followed by a
// single read-modify-write that waits until the output register is free; a new request
// is accepted only once that write is done.
// A new request is taken while the previous result still waits at the output.
// Reset (rst_n, async, active low) marks every entry free and zeroes both totals.
// ----------------------------------------------------------------------------
// sparse_bitset_table_unit
// Sparse bit set kept as a table of 32-bit word entries: test, set, clear.
// ----------------------------------------------------------------------------
module sparse_bitset_table_unit #(
    parameter int ENTRIES          = sbt_pkg::ENTRIES_DEF,
    parameter int BIT_NUMBER_WIDTH = sbt_pkg::BN_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [sbt_pkg::IN_TW-1:0]   s_axis_tdata,  // op[1:0], bit_number[17:2], zero pad
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [sbt_pkg::OUT_TW-1:0]  m_axis_tdata   // was_set[0], changed[1],
                                                       // bits_set[11:2], words_used[16:12],
                                                       // status[18:17], zero pad
);

    sbt_pkg::cmd_t                cmd;
    sbt_pkg::stat_t               stat;
    logic                         was_set;
    logic                         changed;
    logic [sbt_pkg::BITS_W-1:0]   bits_set;
    logic [sbt_pkg::WORDS_W-1:0]  words_used;
    logic [sbt_pkg::STAT_W-1:0]   status;

    sbt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbt_datapath #(
        .ENTRIES          (ENTRIES),
        .BIT_NUMBER_WIDTH (BIT_NUMBER_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .op         (s_axis_tdata[1:0]),
        .bit_number (s_axis_tdata[17:2]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .was_set    (was_set),
        .changed    (changed),
        .bits_set   (bits_set),
        .words_used (words_used),
        .status     (status)
    );

    // Pack the result word
    assign m_axis_tdata = {5'd0, status, words_used, bits_set, changed, was_set};

endmodule

### design/sbt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]             wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/sbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_ctrl
// Request sequencer: accept, scan the table, then one read-modify-write.
// ----------------------------------------------------------------------------
module sbt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  sbt_pkg::stat_t stat,
    output sbt_pkg::cmd_t  cmd
);

    sbt_pkg::state_t state_reg;
    sbt_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sbt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = sbt_pkg::ST_SCAN;
                end
            end
            sbt_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = sbt_pkg::ST_UPDATE;
                end
            end
            sbt_pkg::ST_UPDATE:
            begin
                // hold until the output register can take the word
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = sbt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### design/sbt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_datapath
// Entry RAM, valid bits, scan match/free search, update and result register.
// ----------------------------------------------------------------------------
module sbt_datapath #(
    parameter int ENTRIES          = sbt_pkg::ENTRIES_DEF,
    parameter int BIT_NUMBER_WIDTH = sbt_pkg::BN_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sbt_pkg::cmd_t                cmd,
    output sbt_pkg::stat_t               stat,
    input  logic [sbt_pkg::OP_W-1:0]     op,
    input  logic [sbt_pkg::BN_W-1:0]     bit_number,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         was_set,
    output logic                         changed,
    output logic [sbt_pkg::BITS_W-1:0]   bits_set,
    output logic [sbt_pkg::WORDS_W-1:0]  words_used,
    output logic [sbt_pkg::STAT_W-1:0]   status
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [sbt_pkg::BN_W-1:0] BN_MASK =
        (BIT_NUMBER_WIDTH >= sbt_pkg::BN_W) ? '1 :
        sbt_pkg::BN_W'((32'd1 << BIT_NUMBER_WIDTH) - 32'd1);

    // Request held for the whole item
    logic [sbt_pkg::OP_W-1:0]   op_reg;
    logic [sbt_pkg::BN_W-1:0]   bn_reg;
    logic [sbt_pkg::BN_W-1:0]   idx;
    logic [sbt_pkg::WORD_W-1:0] word;
    logic [sbt_pkg::MASK_W-1:0] sel;
    logic                       bit_zero;

    // Scan state
    logic [CW-1:0]              scan_cnt_reg;
    logic                       cmp_en_reg;
    logic [AW-1:0]              cmp_idx_reg;
    logic                       issue;
    logic [AW-1:0]              scan_idx;
    logic                       hit_reg;
    logic [AW-1:0]              hit_idx_reg;
    logic [sbt_pkg::MASK_W-1:0] hit_mask_reg;
    logic                       free_reg;
    logic [AW-1:0]              free_idx_reg;

    // Table
    logic [ENTRIES-1:0]         valid_reg;
    logic [ENTRIES-1:0]         valid_next;
    sbt_pkg::entry_t            ram_rdata;
    sbt_pkg::entry_t            ram_wdata;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;

    // Totals and result
    logic [sbt_pkg::BITS_W-1:0]  bit_total_reg;
    logic [sbt_pkg::BITS_W-1:0]  bit_total_next;
    logic [sbt_pkg::WORDS_W-1:0] word_total_reg;
    logic [sbt_pkg::WORDS_W-1:0] word_total_next;
    logic                        was;
    logic                        chg;
    logic [sbt_pkg::STAT_W-1:0]  st;
    logic [sbt_pkg::MASK_W-1:0]  clr_mask;
    logic                        out_valid_reg;
    logic                        was_set_reg;
    logic                        changed_reg;
    logic [sbt_pkg::BITS_W-1:0]  bits_set_reg;
    logic [sbt_pkg::WORDS_W-1:0] words_used_reg;
    logic [sbt_pkg::STAT_W-1:0]  status_reg;

    // Word index and bit select of the held request
    assign bit_zero = (bn_reg == '0);
    assign idx      = bn_reg - sbt_pkg::BN_W'(1);
    assign word     = idx[sbt_pkg::BN_W-1:sbt_pkg::SEL_W];
    assign sel      = sbt_pkg::MASK_W'(1) << idx[sbt_pkg::SEL_W-1:0];

    assign scan_idx = scan_cnt_reg[AW-1:0];
    assign issue    = cmd.scan && (scan_cnt_reg < CW'(ENTRIES));

    assign stat.scan_done = cmp_en_reg && (cmp_idx_reg == AW'(ENTRIES - 1));
    assign stat.out_free  = !out_valid_reg || out_ready;

    sbt_ram #(
        .WIDTH ($bits(sbt_pkg::entry_t)),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_idx),
        .rdata (ram_rdata)
    );

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg <= op;
            bn_reg <= bit_number & BN_MASK;
        end
    end

    // Scan: issue one read a cycle, compare the entry read the cycle before
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            cmp_en_reg   <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= issue;
            if (cmd.start)
            begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else
            begin
                if (issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                    if (!valid_reg[scan_idx] && !free_reg)
                    begin
                        free_reg <= 1'b1;
                    end
                end
                if (cmp_en_reg && valid_reg[cmp_idx_reg] && !hit_reg &&
                    (ram_rdata.word == word))
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Scan payload: indexes and matched mask
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cmp_idx_reg <= scan_idx;
            if (!valid_reg[scan_idx] && !free_reg)
            begin
                free_idx_reg <= scan_idx;
            end
        end
        if (cmp_en_reg && valid_reg[cmp_idx_reg] && !hit_reg &&
            (ram_rdata.word == word))
        begin
            hit_idx_reg  <= cmp_idx_reg;
            hit_mask_reg <= ram_rdata.mask;
        end
    end

    // Read-modify-write of the entry and totals
    always_comb
    begin
        was             = 1'b0;
        chg             = 1'b0;
        st              = sbt_pkg::STAT_OK;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata.word  = word;
        ram_wdata.mask  = hit_mask_reg | sel;
        valid_next      = valid_reg;
        bit_total_next  = bit_total_reg;
        word_total_next = word_total_reg;
        clr_mask        = hit_mask_reg & ~sel;
        if (bit_zero)
        begin
            st = sbt_pkg::STAT_ZERO;
        end
        else
        begin
            was = hit_reg && ((hit_mask_reg & sel) != '0);
            if (op_reg == sbt_pkg::OP_SET && !was)
            begin
                if (hit_reg)
                begin
                    ram_we         = 1'b1;
                    bit_total_next = bit_total_reg + sbt_pkg::BITS_W'(1);
                    chg            = 1'b1;
                end
                else if (free_reg)
                begin
                    ram_we                  = 1'b1;
                    ram_waddr               = free_idx_reg;
                    ram_wdata.mask          = sel;
                    valid_next[free_idx_reg] = 1'b1;
                    word_total_next = word_total_reg + sbt_pkg::WORDS_W'(1);
                    bit_total_next  = bit_total_reg + sbt_pkg::BITS_W'(1);
                    chg             = 1'b1;
                end
                else
                begin
                    st = sbt_pkg::STAT_FULL;
                end
            end
            else if (op_reg == sbt_pkg::OP_CLEAR && was)
            begin
                ram_we         = 1'b1;
                ram_wdata.mask = clr_mask;
                bit_total_next = bit_total_reg - sbt_pkg::BITS_W'(1);
                chg            = 1'b1;
                // an emptied word frees its entry
                if (clr_mask == '0)
                begin
                    valid_next[hit_idx_reg] = 1'b0;
                    word_total_next = word_total_reg - sbt_pkg::WORDS_W'(1);
                end
            end
        end
        if (!cmd.commit)
        begin
            ram_we = 1'b0;
        end
    end

    // Table control state and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            bit_total_reg  <= '0;
            word_total_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                valid_reg      <= valid_next;
                bit_total_reg  <= bit_total_next;
                word_total_reg <= word_total_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            was_set_reg    <= was;
            changed_reg    <= chg;
            bits_set_reg   <= bit_total_next;
            words_used_reg <= word_total_next;
            status_reg     <= st;
        end
    end

    assign out_valid  = out_valid_reg;
    assign was_set    = was_set_reg;
    assign changed    = changed_reg;
    assign bits_set   = bits_set_reg;
    assign words_used = words_used_reg;
    assign status     = status_reg;

endmodule
